>>> rtl/ucdsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucdsh_pkg
// Shared types, scramble constants and the microcode program of the dual
// scramble hash core.
// ----------------------------------------------------------------------------
package ucdsh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned StepW   = 5;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEED_EVEN = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_ODD  = 1'b1;

  // Program layout: one absorb routine per word position, then the finish step
  localparam logic [StepW-1:0] PosOneBase = 5'd15;
  localparam logic [StepW-1:0] FinishStep = 5'd30;

  typedef struct packed {
    logic [WordW-1:0] data_word;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] hash_first;
    logic [WordW-1:0] hash_second;
    logic             hash_valid;
  } out_beat_t;

  // Scramble constants, one per chain and position (A0/A1, B0/B1), indexed by link
  localparam logic [3:0][WordW-1:0] ScrA0 =
    {32'h257E1D83, 32'h12CEB96D, 32'h87085B9F, 32'hCF98B111};
  localparam logic [3:0][WordW-1:0] ScrA1 =
    {32'hBFA49F69, 32'h7C932B89, 32'hD38396FF, 32'hA27416F5};
  localparam logic [3:0][WordW-1:0] ScrB0 =
    {32'hC3EFEA97, 32'h79F8A395, 32'h689B6B9F, 32'hEF0569FB};
  localparam logic [3:0][WordW-1:0] ScrB1 =
    {32'h35BD1EC9, 32'h59C3AF2D, 32'hDDCD1F0F, 32'hC31713DB};

  typedef enum logic [1:0] {
    SQ_NEXT,
    SQ_BR_EVEN,
    SQ_FINISH
  } seq_op_e;

  typedef enum logic [1:0] {
    H_HOLD,
    H_LOAD,
    H_MUL,
    H_ADD_P
  } h_op_e;

  typedef enum logic [2:0] {
    MS_H,
    MS_SWAP_H,
    MS_SHR_H,
    MS_X,
    MS_SWAP_X
  } mul_src_e;

  typedef enum logic [3:0] {
    MK_SEED,
    MK_A0,
    MK_A1,
    MK_A2,
    MK_A3,
    MK_B0,
    MK_B1,
    MK_B2,
    MK_B3
  } mul_k_e;

  typedef enum logic {
    W_HELD,
    W_CUR
  } w_sel_e;

  typedef struct packed {
    seq_op_e  seq;
    h_op_e    h_op;
    logic     p_mul;
    mul_src_e mul_src;
    mul_k_e   mul_k;
    logic     pos;
    w_sel_e   w_sel;
    logic     wb_a;
    logic     wb_b;
    logic     pair_done;
  } ctl_t;

  typedef struct packed {
    logic odd;
    logic fin_hold;
  } stat_t;

  localparam ctl_t CtlNop = '{
    seq: SQ_NEXT, h_op: H_HOLD, p_mul: 1'b0, mul_src: MS_H, mul_k: MK_SEED,
    pos: 1'b0, w_sel: W_HELD, wb_a: 1'b0, wb_b: 1'b0, pair_done: 1'b0
  };

  // Control word for one program step
  function automatic ctl_t ucode(logic [StepW-1:0] step);
    ctl_t             c;
    logic             pos;
    logic [StepW-1:0] s;
    c   = CtlNop;
    pos = (step >= PosOneBase);
    s   = pos ? step - PosOneBase : step;
    if (step == FinishStep) begin
      c.seq = SQ_FINISH;
    end else begin
      c.pos   = pos;
      c.w_sel = pos ? W_CUR : W_HELD;
      case (s)
        5'd0: begin
          c.h_op = H_LOAD;
          c.seq  = pos ? SQ_NEXT : SQ_BR_EVEN;
        end
        5'd1: begin
          c.h_op = H_MUL; c.mul_src = MS_H; c.mul_k = MK_SEED;
        end
        5'd2: begin
          c.h_op = H_MUL; c.mul_src = MS_SWAP_H; c.mul_k = MK_A0;
        end
        5'd3: begin
          c.h_op = H_MUL; c.mul_src = MS_SWAP_H; c.mul_k = MK_A1;
        end
        5'd4: begin
          c.h_op = H_MUL; c.mul_src = MS_SWAP_H; c.mul_k = MK_A2;
        end
        5'd5: begin
          c.h_op = H_MUL; c.mul_src = MS_SWAP_H; c.mul_k = MK_A3;
        end
        5'd6: begin
          c.wb_a = 1'b1;
          c.p_mul = 1'b1; c.mul_src = MS_SWAP_X; c.mul_k = MK_B0;
        end
        5'd7: begin
          c.h_op = H_MUL; c.mul_src = MS_X; c.mul_k = MK_SEED;
        end
        5'd8:  c.h_op = H_ADD_P;
        5'd9: begin
          c.p_mul = 1'b1; c.mul_src = MS_SHR_H; c.mul_k = MK_B1;
        end
        5'd10: begin
          c.h_op = H_MUL; c.mul_src = MS_H; c.mul_k = MK_B2;
        end
        5'd11: c.h_op = H_ADD_P;
        5'd12: begin
          c.p_mul = 1'b1; c.mul_src = MS_SWAP_H; c.mul_k = MK_B3;
        end
        5'd13: c.h_op = H_ADD_P;
        5'd14: begin
          c.wb_b      = 1'b1;
          c.pair_done = pos;
        end
        default: c.seq = SQ_FINISH;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ucdsh_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucdsh_seq
// Step counter and microcode lookup; issues one control word per cycle.
// ----------------------------------------------------------------------------
module ucdsh_seq (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire ucdsh_pkg::stat_t            stat_i,
  output logic                             busy_o,
  output ucdsh_pkg::ctl_t                  ctl_o
);

  logic                        busy_q, busy_d;
  logic [ucdsh_pkg::StepW-1:0] step_q, step_d;
  ucdsh_pkg::ctl_t             word;

  assign word   = ucdsh_pkg::ucode(step_q);
  assign ctl_o  = busy_q ? word : ucdsh_pkg::CtlNop;
  assign busy_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      unique case (word.seq)
        ucdsh_pkg::SQ_NEXT:    step_d = step_q + 1'b1;
        ucdsh_pkg::SQ_BR_EVEN: step_d = stat_i.odd ? step_q + 1'b1
                                                   : ucdsh_pkg::FinishStep;
        ucdsh_pkg::SQ_FINISH:  busy_d = stat_i.fin_hold;
        default:               busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ucdsh_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucdsh_dpath
// Checksum registers, shared 32x32 multiplier, seed registers and the result
// register; all but the seeds are driven by the control word.
// ----------------------------------------------------------------------------
module ucdsh_dpath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                load_i,
  input  wire ucdsh_pkg::in_beat_t           beat_i,
  input  wire ucdsh_pkg::ctl_t               ctl_i,
  input  wire                                cfg_we_i,
  input  wire [ucdsh_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [ucdsh_pkg::WordW-1:0]         cfg_wdata_i,
  output ucdsh_pkg::stat_t                   stat_o,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output ucdsh_pkg::out_beat_t               out_beat_o
);

  localparam int unsigned W = ucdsh_pkg::WordW;
  localparam int unsigned HalfW = W / 2;

  logic [W-1:0] seed_even_q, seed_odd_q;
  logic [W-1:0] sum_a_q, sum_b_q, tot_a_q, tot_b_q;
  logic [W-1:0] held_q, word_q, h_q, x_q, p_q;
  logic         odd_q, seen_q, last_q, out_valid_q;
  ucdsh_pkg::out_beat_t out_q;

  logic [W-1:0] w_val, op_a, op_b, mul_r, seed;
  logic         blocked, emit, br_hold;

  function automatic logic [W-1:0] swap(logic [W-1:0] v);
    return {v[HalfW-1:0], v[W-1:HalfW]};
  endfunction

  assign w_val   = (ctl_i.w_sel == ucdsh_pkg::W_CUR) ? word_q : held_q;
  assign seed    = (ctl_i.pos ? seed_odd_q : seed_even_q) | {{(W-1){1'b0}}, 1'b1};
  assign blocked = out_valid_q && out_stall_i;
  assign emit    = (ctl_i.seq == ucdsh_pkg::SQ_FINISH) && last_q && !blocked;
  assign br_hold = (ctl_i.seq == ucdsh_pkg::SQ_BR_EVEN) && !odd_q;

  always_comb begin
    unique case (ctl_i.mul_src)
      ucdsh_pkg::MS_H:      op_a = h_q;
      ucdsh_pkg::MS_SWAP_H: op_a = swap(h_q);
      ucdsh_pkg::MS_SHR_H:  op_a = {{HalfW{1'b0}}, h_q[W-1:HalfW]};
      ucdsh_pkg::MS_X:      op_a = x_q;
      ucdsh_pkg::MS_SWAP_X: op_a = swap(x_q);
      default:              op_a = h_q;
    endcase
  end

  always_comb begin
    unique case (ctl_i.mul_k)
      ucdsh_pkg::MK_SEED: op_b = seed;
      ucdsh_pkg::MK_A0:   op_b = ctl_i.pos ? ucdsh_pkg::ScrA1[0] : ucdsh_pkg::ScrA0[0];
      ucdsh_pkg::MK_A1:   op_b = ctl_i.pos ? ucdsh_pkg::ScrA1[1] : ucdsh_pkg::ScrA0[1];
      ucdsh_pkg::MK_A2:   op_b = ctl_i.pos ? ucdsh_pkg::ScrA1[2] : ucdsh_pkg::ScrA0[2];
      ucdsh_pkg::MK_A3:   op_b = ctl_i.pos ? ucdsh_pkg::ScrA1[3] : ucdsh_pkg::ScrA0[3];
      ucdsh_pkg::MK_B0:   op_b = ctl_i.pos ? ucdsh_pkg::ScrB1[0] : ucdsh_pkg::ScrB0[0];
      ucdsh_pkg::MK_B1:   op_b = ctl_i.pos ? ucdsh_pkg::ScrB1[1] : ucdsh_pkg::ScrB0[1];
      ucdsh_pkg::MK_B2:   op_b = ctl_i.pos ? ucdsh_pkg::ScrB1[2] : ucdsh_pkg::ScrB0[2];
      ucdsh_pkg::MK_B3:   op_b = ctl_i.pos ? ucdsh_pkg::ScrB1[3] : ucdsh_pkg::ScrB0[3];
      default:            op_b = seed;
    endcase
  end

  // Low word of the product only
  assign mul_r = op_a * op_b;

  assign stat_o.odd      = odd_q;
  assign stat_o.fin_hold = (ctl_i.seq == ucdsh_pkg::SQ_FINISH) && last_q && blocked;
  assign out_valid_o     = out_valid_q;
  assign out_beat_o      = out_q;

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= beat_i.data_word;
      last_q <= beat_i.last;
    end
    unique case (ctl_i.h_op)
      ucdsh_pkg::H_LOAD: begin
        h_q <= sum_a_q + w_val;
        x_q <= sum_b_q + w_val;
      end
      ucdsh_pkg::H_MUL:   h_q <= mul_r;
      ucdsh_pkg::H_ADD_P: h_q <= h_q + p_q;
      default: ;
    endcase
    if (ctl_i.p_mul) begin
      p_q <= mul_r;
    end
    if (br_hold) begin
      held_q <= word_q;
    end
    if (emit) begin
      out_q.hash_first  <= sum_a_q ^ sum_b_q;
      out_q.hash_second <= tot_a_q ^ tot_b_q;
      out_q.hash_valid  <= seen_q;
    end
  end

  // Message state, seeds and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_even_q <= {{(W-1){1'b0}}, 1'b1};
      seed_odd_q  <= {{(W-1){1'b0}}, 1'b1};
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      tot_a_q     <= '0;
      tot_b_q     <= '0;
      odd_q       <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == ucdsh_pkg::CFG_SEED_EVEN) begin
        seed_even_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == ucdsh_pkg::CFG_SEED_ODD) begin
        seed_odd_q <= cfg_wdata_i;
      end
      out_valid_q <= blocked || emit;
      if (emit) begin
        sum_a_q <= '0;
        sum_b_q <= '0;
        tot_a_q <= '0;
        tot_b_q <= '0;
        odd_q   <= 1'b0;
        seen_q  <= 1'b0;
      end else begin
        if (ctl_i.wb_a) begin
          sum_a_q <= h_q;
          tot_a_q <= tot_a_q + h_q;
        end
        if (ctl_i.wb_b) begin
          sum_b_q <= h_q;
          tot_b_q <= tot_b_q + h_q;
        end
        if (br_hold) begin
          odd_q <= 1'b1;
        end
        if (ctl_i.pair_done) begin
          odd_q  <= 1'b0;
          seen_q <= 1'b1;
        end
      end
    end
  end

  // A result clears the whole message state
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (sum_a_q == '0 && sum_b_q == '0 && tot_a_q == '0 && tot_b_q == '0
              && !odd_q && !seen_q))
    else $error("message state not cleared after result");

  // Without a complete block the checksums stay untouched
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !seen_q) |=> (out_q.hash_first == '0 && out_q.hash_second == '0))
    else $error("nonzero hash without a complete block");

  // A block closes only with an even word held
  a_pair_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pair_done |-> odd_q)
    else $error("block closed without a held even word");

endmodule
`default_nettype wire

>>> rtl/userchoice_dual_scramble_hash_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// userchoice_dual_scramble_hash_core
// Dual checksum scramble hash over a stream of 32-bit words, run by a short
// microcode program on one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                 beat
//  -------  ---  ------------------------  ---------------------------------
//  in       in   in_valid_i / in_stall_o   data_word, last
//  out      out  out_valid_o / out_stall_i hash_first, hash_second, hash_valid
//  cfg      in   cfg_we_i                  cfg_idx_i, cfg_wdata_i (seeds)
//
//  An even word of a block runs only its hold and finish steps; an odd word
//  runs two absorb routines of 15 steps each through the single 32x32
//  multiplier, then the finish step. The input stall drops once the finish
//  step is done, so a new word is taken only after the last one has finished.
//  Reset clears the checksums, totals and seeds (seeds to one) at once.
//  A finished result sits in the output register; a new word is taken while
//  it waits, and the program holds at its finish step only when a second
//  result is due and the first is still stalled.
//
module userchoice_dual_scramble_hash_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire ucdsh_pkg::in_beat_t         in_beat_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output ucdsh_pkg::out_beat_t             out_beat_o,
  input  wire                              cfg_we_i,
  input  wire [ucdsh_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [ucdsh_pkg::WordW-1:0]       cfg_wdata_i
);

  logic             busy;
  logic             accept;
  ucdsh_pkg::ctl_t  ctl;
  ucdsh_pkg::stat_t stat;

  // Take a new beat only while the program is idle
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  ucdsh_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .stat_i  (stat),
    .busy_o  (busy),
    .ctl_o   (ctl)
  );

  ucdsh_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .beat_i      (in_beat_i),
    .ctl_i       (ctl),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual scramble hash core. Drives word beats
// with random gaps and output back-pressure, mirrors the hash in a local
// model and compares every result beat against it, field by field.
// ----------------------------------------------------------------------------
module tb_top;

  // Cycles to let the microcode settle after the last result: an odd word
  // runs 31 steps, so leave some margin on top of that.
  localparam int unsigned SettleCycles = 40;
  // Length of the long receiver hold-off in the back-pressure test.
  localparam int unsigned HoldoffCycles = 300;

  // Scramble multipliers, [word position][link] for each checksum chain.
  localparam logic [31:0] MulA [2][4] = '{
    '{32'hCF98B111, 32'h87085B9F, 32'h12CEB96D, 32'h257E1D83},
    '{32'hA27416F5, 32'hD38396FF, 32'h7C932B89, 32'hBFA49F69}
  };
  localparam logic [31:0] MulB [2][4] = '{
    '{32'hEF0569FB, 32'h689B6B9F, 32'h79F8A395, 32'hC3EFEA97},
    '{32'hC31713DB, 32'hDDCD1F0F, 32'h59C3AF2D, 32'h35BD1EC9}
  };

  // --------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  ucdsh_pkg::in_beat_t           in_beat_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  ucdsh_pkg::out_beat_t          out_beat_o;
  logic                          cfg_we_i    = 1'b0;
  logic [ucdsh_pkg::CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [ucdsh_pkg::WordW-1:0]   cfg_wdata_i = '0;

  userchoice_dual_scramble_hash_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Hash model state: seeds, checksums, totals and block pairing
  // --------------------------------------------------------------------------
  logic [31:0] seed_even  = 32'd1;
  logic [31:0] seed_odd   = 32'd1;
  logic [31:0] chk_a      = '0;
  logic [31:0] chk_b      = '0;
  logic [31:0] tot_a      = '0;
  logic [31:0] tot_b      = '0;
  logic        word_held  = 1'b0;
  logic        pair_seen  = 1'b0;
  logic [31:0] even_word  = '0;

  ucdsh_pkg::out_beat_t pending_hashes[$];
  int unsigned          error_cnt = 0;

  // Idle and stall odds in percent, changed per traffic phase.
  int unsigned send_idle_pct = 26;
  int unsigned stall_pct     = 77;

  // Bump to ask the receiver process for one long hold-off.
  int unsigned holdoff_req  = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;

  function automatic logic [31:0] swap_halves(logic [31:0] x);
    return {x[15:0], x[31:16]};
  endfunction

  // Fold one word into both checksum chains at block position pos.
  task automatic absorb_word(input logic [31:0] w, input logic pos);
    logic [31:0] seed;
    logic [31:0] h;
    seed = (pos ? seed_odd : seed_even) | 32'd1;

    h = chk_a + w;
    h = h * seed;
    h = swap_halves(h) * MulA[pos][0];
    h = swap_halves(h) * MulA[pos][1];
    h = swap_halves(h) * MulA[pos][2];
    h = swap_halves(h) * MulA[pos][3];
    chk_a = h;
    tot_a = tot_a + h;

    h = chk_b + w;
    h = swap_halves(h) * MulB[pos][0] + h * seed;
    h = (h >> 16) * MulB[pos][1] + h * MulB[pos][2];
    h = swap_halves(h) * MulB[pos][3] + h;
    chk_b = h;
    tot_b = tot_b + h;
  endtask

  // Advance the model by one accepted word; queue a hash on the last word.
  task automatic hash_word(input logic [31:0] w, input logic last);
    ucdsh_pkg::out_beat_t r;
    if (word_held) begin
      // Odd word completes the block: hash the held even word, then this one
      absorb_word(even_word, 1'b0);
      absorb_word(w, 1'b1);
      pair_seen = 1'b1;
      word_held = 1'b0;
      even_word = '0;
    end else begin
      // Even word: just hold it; a trailing one never reaches the checksums
      even_word = w;
      word_held = 1'b1;
    end
    if (last) begin
      r.hash_first  = chk_a ^ chk_b;
      r.hash_second = tot_a ^ tot_b;
      r.hash_valid  = pair_seen;
      pending_hashes.push_back(r);
      chk_a = '0; chk_b = '0; tot_a = '0; tot_b = '0;
      word_held = 1'b0; pair_seen = 1'b0; even_word = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HoldoffCycles;
      out_stall_i  <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i  <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted beat with the oldest hash
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ucdsh_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        $error("unexpected result beat: hash_first %h hash_second %h hash_valid %b",
               out_beat_o.hash_first, out_beat_o.hash_second, out_beat_o.hash_valid);
        error_cnt++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_beat_o.hash_first !== want.hash_first) begin
          $error("hash_first: expected %h, actual %h",
                 want.hash_first, out_beat_o.hash_first);
          error_cnt++;
        end
        if (out_beat_o.hash_second !== want.hash_second) begin
          $error("hash_second: expected %h, actual %h",
                 want.hash_second, out_beat_o.hash_second);
          error_cnt++;
        end
        if (out_beat_o.hash_valid !== want.hash_valid) begin
          $error("hash_valid: expected %b, actual %b",
                 want.hash_valid, out_beat_o.hash_valid);
          error_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one word beat and hold it until the core takes it. Valid stays high
  // afterwards so back-to-back beats need no gap.
  task automatic send_word(input logic [31:0] w, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i          <= 1'b1;
    in_beat_i.data_word <= w;
    in_beat_i.last      <= last;
    do @(posedge clk_i); while (in_stall_o);
    hash_word(w, last);
  endtask

  // Drop valid, drain every queued hash, then let the microcode settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [ucdsh_pkg::CfgIdxW-1:0] idx,
                            input logic [31:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == ucdsh_pkg::CFG_SEED_EVEN) seed_even = val;
    else                                 seed_odd  = val;
  endtask

  // Mostly plain random words, with zero, all-ones and one-hot mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_message(input int unsigned n_words);
    for (int unsigned i = 0; i < n_words; i++) begin
      send_word(pick_word(), i == n_words - 1);
    end
  endtask

  // Mostly short messages; a few long ones exercise the running totals.
  function automatic int unsigned pick_length();
    if ($urandom_range(19) == 0) return $urandom_range(40, 9);
    return $urandom_range(8, 1);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Directed beats with the reset seeds: lone words, exact pairs and
  // trailing unpaired words, with the word extremes.
  task automatic test_directed_messages();
    // lone trailing word: no full block, result must flag invalid
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    // exactly one block
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    // one block plus a trailing word that must not touch the checksums
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h9ABC_DEF0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    // two blocks of alternating patterns
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    // back-to-back single-block messages check the clear between them
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'hFFFF_0000, 1'b1);
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'hFFFF_0000, 1'b1);
    wait_idle();
  endtask

  // Seed extremes: zero (forced odd to one), all-ones, even values whose low
  // bit the core must set, and one random pair.
  task automatic test_seed_extremes();
    logic [31:0] evens [4];
    logic [31:0] odds  [4];
    evens = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, $urandom};
    odds  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002, $urandom};
    foreach (evens[i]) begin
      write_seed(ucdsh_pkg::CFG_SEED_EVEN, evens[i]);
      write_seed(ucdsh_pkg::CFG_SEED_ODD,  odds[i]);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_message(3);
    end
    wait_idle();
  endtask

  // Random messages over three idle mixes, with fresh seeds per phase.
  task automatic test_random_traffic();
    int unsigned sender_pct [3];
    int unsigned recv_pct   [3];
    int unsigned words;
    sender_pct = '{26, 77, 0};
    recv_pct   = '{77, 26, 0};
    for (int p = 0; p < 3; p++) begin
      write_seed(ucdsh_pkg::CFG_SEED_EVEN, $urandom);
      write_seed(ucdsh_pkg::CFG_SEED_ODD,  $urandom);
      send_idle_pct = sender_pct[p];
      stall_pct     = recv_pct[p];
      words = 0;
      while (words < 400) begin
        int unsigned n;
        n = pick_length();
        send_message(n);
        words += n;
      end
    end
    wait_idle();
  endtask

  // Hold the receiver off for a long stretch while short messages keep
  // coming, so the output register fills and the core stalls its input.
  task automatic test_output_backpressure();
    write_seed(ucdsh_pkg::CFG_SEED_EVEN, 32'hFFFF_FFFF);
    write_seed(ucdsh_pkg::CFG_SEED_ODD,  32'h0000_0000);
    send_idle_pct = 0;
    stall_pct     = 0;
    holdoff_req++;
    for (int i = 0; i < 40; i++) begin
      send_message($urandom_range(2, 1));
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_messages();
    test_seed_extremes();
    test_random_traffic();
    test_output_backpressure();

    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
